// ----- rtl/core/piecewise_linear_interpolator_macros.svh -----
// Assertion macros for the checker file.
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_MACROS_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_MACROS_SVH

// Checked only while the block is out of reset.
`define PLI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define PLI_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- rtl/core/pli_pkg.sv -----
package pli_pkg;

    localparam int DATA_W      = 32;
    localparam int IDX_W       = 10;
    localparam int CFG_W       = 11;
    localparam int REGION_W    = 2;
    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int PROD_W      = 2 * DATA_W;
    localparam int MAG_W       = DATA_W + 2;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [REGION_W-1:0] REGION_INTERP = 2'd0;
    localparam logic [REGION_W-1:0] REGION_BELOW  = 2'd1;
    localparam logic [REGION_W-1:0] REGION_ABOVE  = 2'd2;

endpackage

// ----- rtl/core/pli_ram.sv -----
module pli_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/pli_mul.sv -----
module pli_mul (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [pli_pkg::DATA_W-1:0]   i_a,
    input  logic [pli_pkg::DATA_W-1:0]   i_b,
    output logic                         o_done,
    output logic [pli_pkg::PROD_W-1:0]   o_prod
);

    localparam int CW = $clog2(pli_pkg::DATA_W);

    logic [pli_pkg::DATA_W-1:0] r_a;
    logic [pli_pkg::DATA_W-1:0] r_hi;
    logic [pli_pkg::DATA_W-1:0] r_lo;
    logic [CW-1:0]              r_cnt;
    logic                       r_busy;
    logic                       r_done;
    logic [pli_pkg::DATA_W:0]   sum;

    assign sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_a} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(pli_pkg::DATA_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a  <= i_a;
            r_hi <= '0;
            r_lo <= i_b;
        end else if (r_busy) begin
            r_hi <= sum[pli_pkg::DATA_W:1];
            r_lo <= {sum[0], r_lo[pli_pkg::DATA_W-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = {r_hi, r_lo};

endmodule

// ----- rtl/core/pli_div.sv -----
module pli_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [pli_pkg::PROD_W-1:0]  i_dvd,
    input  logic [pli_pkg::DATA_W-1:0]  i_dsr,
    output logic                        o_done,
    output logic [pli_pkg::MAG_W-1:0]   o_mag
);

    localparam int CW = $clog2(pli_pkg::PROD_W);

    logic [pli_pkg::PROD_W-1:0] r_dvd;
    logic [pli_pkg::DATA_W-1:0] r_dsr;
    logic [pli_pkg::DATA_W-1:0] r_rem;
    logic [CW-1:0]              r_cnt;
    logic                       r_busy;
    logic                       r_done;
    logic [pli_pkg::DATA_W:0]   trial;
    logic [pli_pkg::DATA_W:0]   diff;
    logic                       ge;

    assign trial = {r_rem, r_dvd[pli_pkg::PROD_W-1]};
    assign diff  = trial - {1'b0, r_dsr};
    assign ge    = trial >= {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(pli_pkg::PROD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dvd;
            r_dsr <= i_dsr;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? diff[pli_pkg::DATA_W-1:0] : trial[pli_pkg::DATA_W-1:0];
            r_dvd <= {r_dvd[pli_pkg::PROD_W-2:0], ge};
        end
    end

    // The quotient saturates when it does not fit the magnitude width.
    assign o_mag  = (|r_dvd[pli_pkg::PROD_W-1:pli_pkg::MAG_W]) ? '1
                                                               : r_dvd[pli_pkg::MAG_W-1:0];
    assign o_done = r_done;

endmodule

// ----- rtl/core/piecewise_linear_interpolator.sv -----
// Loads are written to the table in the cycle they are accepted; no item is accepted while a
// query is in progress. A clamped query goes from S_FIRST (and S_LAST at the top) to S_DONE.
// An interpolated query searches upward, reading at most entries_in_use entries; then the
// serial multiplier (one bit per cycle) and divider (one quotient bit per cycle) dominate.
// Reset is synchronous and active low: control clears and entries_in_use returns to the
// table depth; the table contents are kept and hold no defined value until loaded.
module piecewise_linear_interpolator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_op,
    input  logic [pli_pkg::IDX_W-1:0]           i_entry_index,
    input  logic signed [pli_pkg::DATA_W-1:0]   i_entry_x,
    input  logic signed [pli_pkg::DATA_W-1:0]   i_entry_y,
    input  logic signed [pli_pkg::DATA_W-1:0]   i_query_x,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [pli_pkg::DATA_W-1:0]   o_value,
    output logic [pli_pkg::REGION_W-1:0]        o_region,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pli_pkg::CFG_W-1:0]           i_cfg_entries_in_use
);

    localparam int DW = pli_pkg::DATA_W;
    localparam int AW = pli_pkg::ADDR_W;
    localparam int NW = pli_pkg::CNT_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FIRST = 4'd1;
    localparam logic [3:0] S_LAST  = 4'd2;
    localparam logic [3:0] S_SRCH  = 4'd3;
    localparam logic [3:0] S_CALC  = 4'd4;
    localparam logic [3:0] S_MUL   = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_FIN   = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0]                    r_state, n_state;
    logic [NW-1:0]                 r_n;
    logic [AW-1:0]                 r_idx, n_idx;
    logic signed [DW-1:0]          r_q;
    logic signed [DW-1:0]          r_x0, r_y0, r_x1, r_y1;
    logic signed [DW-1:0]          r_res, n_res;
    logic [pli_pkg::REGION_W-1:0]  r_region, n_region;
    logic [DW-1:0]                 r_ud;
    logic                          r_neg;
    logic                          r_out_valid;
    logic signed [DW-1:0]          r_value;
    logic [pli_pkg::REGION_W-1:0]  r_out_region;

    logic                          in_acc;
    logic                          we;
    logic [AW-1:0]                 rd_addr;
    logic [2*DW-1:0]               rdata;
    logic signed [DW-1:0]          rx, ry;
    logic                          keep_prev;
    logic                          take_cur;
    logic signed [DW:0]            dx, dq, dy;
    logic [DW:0]                   ax, aq, ay;
    logic                          mul_start, mul_done, div_start, div_done;
    logic [pli_pkg::PROD_W-1:0]    prod;
    logic [pli_pkg::MAG_W-1:0]     mag;
    logic signed [DW+3:0]          fin_sum;
    logic                          slot_free;
    logic [NW-1:0]                 cfg_n;

    assign in_acc    = i_in_valid && o_in_ready;
    assign we        = in_acc && (i_op == pli_pkg::OP_LOAD)
                       && (32'(i_entry_index) < pli_pkg::TABLE_DEPTH);
    assign rx        = rdata[2*DW-1:DW];
    assign ry        = rdata[DW-1:0];
    assign slot_free = !r_out_valid || i_out_ready;

    pli_ram #(
        .WIDTH (2 * DW),
        .DEPTH (pli_pkg::TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (AW'(i_entry_index)),
        .i_wdata ({i_entry_x, i_entry_y}),
        .i_raddr (rd_addr),
        .o_rdata (rdata)
    );

    assign dx = {r_x1[DW-1], r_x1} - {r_x0[DW-1], r_x0};
    assign dq = {r_q[DW-1], r_q} - {r_x0[DW-1], r_x0};
    assign dy = {r_y1[DW-1], r_y1} - {r_y0[DW-1], r_y0};
    assign ax = dx[DW] ? -dx : dx;
    assign aq = dq[DW] ? -dq : dq;
    assign ay = dy[DW] ? -dy : dy;

    assign mul_start = (r_state == S_CALC) && (dx != '0);
    assign div_start = (r_state == S_MUL) && mul_done;

    pli_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (ay[DW-1:0]),
        .i_b     (aq[DW-1:0]),
        .o_done  (mul_done),
        .o_prod  (prod)
    );

    pli_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_dvd   (prod),
        .i_dsr   (r_ud),
        .o_done  (div_done),
        .o_mag   (mag)
    );

    assign fin_sum = r_neg ? ((DW+4)'(r_y0) - $signed({2'b00, mag}))
                           : ((DW+4)'(r_y0) + $signed({2'b00, mag}));

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_res     = r_res;
        n_region  = r_region;
        rd_addr   = r_idx;
        keep_prev = 1'b0;
        take_cur  = 1'b0;
        case (r_state)
            S_IDLE: begin
                rd_addr = '0;
                if (in_acc && (i_op == pli_pkg::OP_QUERY)) begin
                    n_state = S_FIRST;
                end
            end
            S_FIRST: begin
                if (r_q <= rx) begin
                    n_res    = ry;
                    n_region = pli_pkg::REGION_BELOW;
                    n_state  = S_DONE;
                end else begin
                    keep_prev = 1'b1;
                    rd_addr   = AW'(r_n - 1'b1);
                    n_state   = S_LAST;
                end
            end
            S_LAST: begin
                if (r_q >= rx) begin
                    n_res    = ry;
                    n_region = pli_pkg::REGION_ABOVE;
                    n_state  = S_DONE;
                end else begin
                    n_idx   = AW'(1);
                    rd_addr = AW'(1);
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                if (((NW'(r_idx) + 1'b1) < r_n) && (r_q > rx)) begin
                    keep_prev = 1'b1;
                    n_idx     = r_idx + 1'b1;
                    rd_addr   = r_idx + 1'b1;
                end else begin
                    take_cur = 1'b1;
                    n_state  = S_CALC;
                end
            end
            S_CALC: begin
                n_region = pli_pkg::REGION_INTERP;
                if (dx == '0) begin
                    n_res   = r_y0;
                    n_state = S_DONE;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (mul_done) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (fin_sum > (DW+4)'(32'sh7FFF_FFFF)) begin
                    n_res = {1'b0, {(DW-1){1'b1}}};
                end else if (fin_sum < -(DW+4)'(64'sh8000_0000)) begin
                    n_res = {1'b1, {(DW-1){1'b0}}};
                end else begin
                    n_res = fin_sum[DW-1:0];
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign cfg_n = (i_cfg_entries_in_use == '0) ? NW'(1)
                 : (32'(i_cfg_entries_in_use) > pli_pkg::TABLE_DEPTH)
                   ? NW'(pli_pkg::TABLE_DEPTH) : NW'(i_cfg_entries_in_use);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_n         <= NW'(pli_pkg::TABLE_DEPTH);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_n <= cfg_n;
            end
            if ((r_state == S_DONE) && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_res    <= n_res;
        r_region <= n_region;
        if (in_acc) begin
            r_q <= i_query_x;
        end
        if (keep_prev) begin
            r_x0 <= rx;
            r_y0 <= ry;
        end
        if (take_cur) begin
            r_x1 <= rx;
            r_y1 <= ry;
        end
        if (r_state == S_CALC) begin
            r_ud  <= ax[DW-1:0];
            r_neg <= dy[DW] ^ dq[DW] ^ dx[DW];
        end
        if ((r_state == S_DONE) && slot_free) begin
            r_value      <= r_res;
            r_out_region <= r_region;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_value     = r_value;
    assign o_region    = r_out_region;

endmodule

// ----- rtl/core/pli_checker.sv -----
`include "piecewise_linear_interpolator_macros.svh"

module pli_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                o_in_ready,
    input  logic                                i_op,
    input  logic [pli_pkg::IDX_W-1:0]           i_entry_index,
    input  logic signed [pli_pkg::DATA_W-1:0]   i_entry_x,
    input  logic signed [pli_pkg::DATA_W-1:0]   i_entry_y,
    input  logic signed [pli_pkg::DATA_W-1:0]   i_query_x,
    input  logic                                o_out_valid,
    input  logic                                i_out_ready,
    input  logic signed [pli_pkg::DATA_W-1:0]   o_value,
    input  logic [pli_pkg::REGION_W-1:0]        o_region,
    input  logic                                i_cfg_valid,
    input  logic                                o_cfg_ready,
    input  logic [pli_pkg::CFG_W-1:0]           i_cfg_entries_in_use
);

`PLI_ASSERT(a_out_hold, (o_out_valid && !i_out_ready) |=> o_out_valid, "result dropped")
`PLI_ASSERT(a_out_stable, (o_out_valid && !i_out_ready) |=> $stable({o_value, o_region}), "moved")
`PLI_ASSERT(a_region_code, o_out_valid |-> (o_region <= pli_pkg::REGION_ABOVE), "bad region")
`PLI_ASSERT_ALWAYS(a_reset_quiet, !i_rst_n |=> !o_out_valid, "result after reset")

endmodule

bind piecewise_linear_interpolator pli_checker u_pli_checker (.*);

// ----- tb/sv/tb_piecewise_linear_interpolator.sv -----
`timescale 1ns / 1ps

module tb_piecewise_linear_interpolator;

    localparam int  DATA_W       = pli_pkg::DATA_W;
    localparam int  REGION_W     = pli_pkg::REGION_W;
    localparam int  IDX_W        = pli_pkg::IDX_W;
    localparam int  CFG_W        = pli_pkg::CFG_W;
    localparam int  TABLE_DEPTH  = pli_pkg::TABLE_DEPTH;
    localparam int  CYCLE_LIMIT  = 3000000;
    localparam int  DRAIN_CYCLES = 1300;
    localparam int  LONG_HOLD    = 400;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [REGION_W-1:0]      rgn;
    } t_answer;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic                      in_op;
    logic [IDX_W-1:0]          in_entry_index;
    logic signed [DATA_W-1:0]  in_entry_x;
    logic signed [DATA_W-1:0]  in_entry_y;
    logic signed [DATA_W-1:0]  in_query_x;
    logic                      out_valid;
    logic                      out_ready;
    logic signed [DATA_W-1:0]  out_value;
    logic [REGION_W-1:0]       out_region;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_W-1:0]          cfg_data;

    logic signed [DATA_W-1:0]  bp_x [TABLE_DEPTH];
    logic signed [DATA_W-1:0]  bp_y [TABLE_DEPTH];
    logic [CFG_W-1:0]          entries_cfg;
    t_answer                   pending_answers [$];
    int                        error_count;
    int                        items_sent;
    int                        cycle_count;
    bit                        idle_on;
    bit                        long_hold_req;
    int                        stall_left;

    piecewise_linear_interpolator uut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (in_valid),
        .o_in_ready           (in_ready),
        .i_op                 (in_op),
        .i_entry_index        (in_entry_index),
        .i_entry_x            (in_entry_x),
        .i_entry_y            (in_entry_y),
        .i_query_x            (in_query_x),
        .o_out_valid          (out_valid),
        .i_out_ready          (out_ready),
        .o_value              (out_value),
        .o_region             (out_region),
        .i_cfg_valid          (cfg_valid),
        .o_cfg_ready          (cfg_ready),
        .i_cfg_entries_in_use (cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("piecewise_linear_interpolator verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (long_hold_req) begin
            stall_left = LONG_HOLD;
            long_hold_req = 1'b0;
        end
        if (stall_left > 0) begin
            out_ready <= 1'b0;
            stall_left--;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            out_ready <= 1'b0;
            stall_left = $urandom_range(0, 8);
        end else begin
            out_ready <= 1'b1;
        end
    end

    function automatic t_answer interpolate(input logic signed [DATA_W-1:0] q);
        t_answer    ans;
        int         n;
        int         i;
        longint     x0, x1, y0, y1, dx, dq, dy, res;
        logic [67:0] ua, ub, ud, mag;
        bit         neg;
        n = (entries_cfg == 0) ? 1 : (entries_cfg > TABLE_DEPTH) ? TABLE_DEPTH : entries_cfg;
        if (q <= bp_x[0]) begin
            ans.value = bp_y[0];
            ans.rgn = pli_pkg::REGION_BELOW;
        end else if (q >= bp_x[n-1]) begin
            ans.value = bp_y[n-1];
            ans.rgn = pli_pkg::REGION_ABOVE;
        end else begin
            i = 0;
            while (i + 2 < n && q > bp_x[i+1])
                i++;
            x0 = bp_x[i];
            x1 = bp_x[i+1];
            y0 = bp_y[i];
            y1 = bp_y[i+1];
            dx = x1 - x0;
            dq = longint'(q) - x0;
            dy = y1 - y0;
            ans.rgn = pli_pkg::REGION_INTERP;
            if (dx == 0) begin
                ans.value = y0[DATA_W-1:0];
            end else begin
                neg = (dy < 0) ^ (dq < 0) ^ (dx < 0);
                ua = 68'((dy < 0) ? -dy : dy);
                ub = 68'((dq < 0) ? -dq : dq);
                ud = 68'((dx < 0) ? -dx : dx);
                mag = (ua * ub) / ud;
                if (mag > 68'h3FFFFFFFF)
                    mag = 68'h3FFFFFFFF;
                res = neg ? y0 - longint'(mag) : y0 + longint'(mag);
                if (res > 64'sd2147483647)
                    res = 64'sd2147483647;
                if (res < -64'sd2147483648)
                    res = -64'sd2147483648;
                ans.value = res[DATA_W-1:0];
            end
        end
        return ans;
    endfunction

    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && out_valid && out_ready) begin
            if (pending_answers.size() == 0) begin
                $display("%0t: unexpected result value %h region %0d",
                         $time, out_value, out_region);
                error_count++;
            end else begin
                want = pending_answers.pop_front();
                if (out_value !== want.value) begin
                    $display("%0t: value expected %h actual %h", $time, want.value, out_value);
                    error_count++;
                end
                if (out_region !== want.rgn) begin
                    $display("%0t: region expected %0d actual %0d",
                             $time, want.rgn, out_region);
                    error_count++;
                end
            end
        end
    end

    task automatic send_item(input logic op, input logic [IDX_W-1:0] idx,
                             input logic signed [DATA_W-1:0] ex,
                             input logic signed [DATA_W-1:0] ey,
                             input logic signed [DATA_W-1:0] qx);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        in_valid       <= 1'b1;
        in_op          <= op;
        in_entry_index <= idx;
        in_entry_x     <= ex;
        in_entry_y     <= ey;
        in_query_x     <= qx;
        do @(posedge i_clk); while (!in_ready);
        items_sent++;
        if (op == pli_pkg::OP_LOAD) begin
            bp_x[idx] = ex;
            bp_y[idx] = ey;
        end else begin
            pending_answers.push_back(interpolate(qx));
        end
    endtask

    task automatic load_entry(input int idx, input logic signed [DATA_W-1:0] ex,
                              input logic signed [DATA_W-1:0] ey);
        send_item(pli_pkg::OP_LOAD, IDX_W'(idx), ex, ey, $urandom);
    endtask

    task automatic query(input logic signed [DATA_W-1:0] qx);
        send_item(pli_pkg::OP_QUERY, IDX_W'($urandom), $urandom, $urandom, qx);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_entries_in_use(input logic [CFG_W-1:0] n);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= n;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        entries_cfg = n;
    endtask

    // Ascending x with random steps sized to the span; a zero step now and then
    // gives repeated breakpoints. Unordered tables get fully random x.
    task automatic load_table(input int n, input bit ordered);
        longint span, x;
        span = 64'd4294967295 / (n + 1);
        x = -64'sd2147483648 + $urandom_range(0, 32'(span - 1));
        for (int i = 0; i < n; i++) begin
            if (ordered)
                load_entry(i, x[DATA_W-1:0], $urandom);
            else
                load_entry(i, $urandom, $urandom);
            x = x + (($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 32'(span)));
        end
    endtask

    function automatic logic signed [DATA_W-1:0] query_point(input int n);
        int  i;
        longint a, b;
        i = $urandom_range(0, (n > 1) ? n - 2 : 0);
        a = bp_x[i];
        b = bp_x[(n > 1) ? i + 1 : 0];
        case ($urandom_range(0, 9))
            0: return bp_x[i];
            1: return $urandom;
            2: return bp_x[n-1] + $urandom_range(0, 3);
            default: begin
                if (b > a)
                    return DATA_W'(a + 1 + longint'($urandom) % (b - a));
                return DATA_W'(a);
            end
        endcase
    endfunction

    task automatic test_single_entry();
        set_entries_in_use(1);
        load_entry(0, 32'sh0001_0000, 32'sh7FFF_FFFF);
        query(32'sh8000_0000);
        query(32'sh0001_0000);
        query(32'sh0001_0001);
        query(32'sh7FFF_FFFF);
        set_entries_in_use(0);
        query(32'sh0000_0000);
        query(32'sh0002_0000);
    endtask

    task automatic test_extreme_span();
        set_entries_in_use(2);
        load_entry(0, 32'sh8000_0000, 32'sh7FFF_FFFF);
        load_entry(1, 32'sh7FFF_FFFF, 32'sh8000_0000);
        query(32'sh0000_0000);
        query(32'sh8000_0001);
        query(32'sh7FFF_FFFE);
        load_entry(0, 32'sh8000_0000, 32'sh8000_0000);
        load_entry(1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        query(32'sh0000_0000);
        query(32'sh8000_0001);
        query(32'sh7FFF_FFFE);
        query(32'sh7FFF_FFFF);
    endtask

    task automatic test_small_table();
        set_entries_in_use(8);
        load_table(8, 1'b1);
        for (int i = 0; i < 8; i++)
            query(bp_x[i]);
        query(query_point(8));
        query(query_point(8));
    endtask

    // Only the first and the last entry are loaded, so every query clamps.
    task automatic test_table_depth();
        set_entries_in_use(CFG_W'(2047));
        load_entry(0, 32'sh8000_0100, $urandom);
        load_entry(TABLE_DEPTH - 1, 32'sh7FFF_FF00, $urandom);
        query(32'sh8000_0000);
        query(32'sh8000_0100);
        query(32'sh7FFF_FF00);
        query(32'sh7FFF_FFFF);
        set_entries_in_use(CFG_W'(TABLE_DEPTH));
        query(32'sh8000_0000);
        query(32'sh7FFF_FF00);
        query(32'sh7FFF_FFFF);
    endtask

    task automatic test_back_pressure();
        set_entries_in_use(4);
        load_table(4, 1'b1);
        long_hold_req = 1'b1;
        for (int i = 0; i < 20; i++)
            query(query_point(4));
    endtask

    task automatic test_random_tables(input int item_goal);
        int n;
        while (items_sent < item_goal) begin
            case ($urandom_range(0, 9))
                0:       n = 1;
                1:       n = $urandom_range(13, 64);
                default: n = $urandom_range(2, 12);
            endcase
            set_entries_in_use(CFG_W'(n));
            load_table(n, $urandom_range(0, 4) != 0);
            repeat ($urandom_range(10, 30)) begin
                case ($urandom_range(0, 19))
                    0:  load_entry($urandom_range(0, n - 1), $urandom, $urandom);
                    1:  load_entry($urandom_range(0, TABLE_DEPTH - 1), $urandom, $urandom);
                    default: query(query_point(n));
                endcase
            end
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        in_valid       = 1'b0;
        in_op          = pli_pkg::OP_LOAD;
        in_entry_index = '0;
        in_entry_x     = '0;
        in_entry_y     = '0;
        in_query_x     = '0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        entries_cfg    = CFG_W'(TABLE_DEPTH);
        items_sent     = 0;
        long_hold_req  = 1'b0;
        idle_on        = 1'b1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_entry();
        test_extreme_span();
        test_small_table();
        test_back_pressure();
        test_table_depth();
        test_random_tables(items_sent + 620);
        idle_on = 1'b0;
        test_random_tables(items_sent + 100);

        wait_drained();
        if (error_count == 0)
            $display("piecewise_linear_interpolator verification clean");
        else
            $display("piecewise_linear_interpolator verification failed");
        $finish;
    end

endmodule
